>>> rtl/fibonacci_sphere_point_gen_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spiral sphere point generator
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_SPHERE_POINT_GEN_UNIT_DEFINES_SVH
`define FIBONACCI_SPHERE_POINT_GEN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FSPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FSPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSPG_ASSERT_IMP(lbl, ante, cons, msg)
`define FSPG_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/fspg_pkg.sv
// ----------------------------------------------------------------------------
// fspg_pkg
// Constants, register indexes and the arctangent table of the point generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fspg_pkg;

    localparam int MAX_POINTS   = 4096;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int NUM_STAGES   = 40;

    localparam logic [1:0] CFG_POINT_COUNT   = 2'd0;
    localparam logic [1:0] CFG_TURN_STEP     = 2'd1;
    localparam logic [1:0] CFG_SPHERE_RADIUS = 2'd2;

    localparam logic [12:0] RST_POINT_COUNT   = 13'd256;
    localparam logic [31:0] RST_TURN_STEP     = 32'd2654435769;
    localparam logic [31:0] RST_SPHERE_RADIUS = 32'd65536;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

`default_nettype wire

>>> rtl/fibonacci_sphere_point_gen_unit.sv
// ----------------------------------------------------------------------------
// fibonacci_sphere_point_gen_unit
// Spiral lattice point generator: index in, Q16.16 x, y and z out.
// ----------------------------------------------------------------------------
// The unit takes one point index per cycle while the output is not stalled and
// returns its coordinates in order, through 40 register stages. The depth is
// set by the 16-step restoring divider for index/(count-1), followed by the
// 16-step square root and the split 32x33 output multiply; the 24-step CORDIC
// runs beside the divider. When the result at the output is not taken, the
// whole pipeline holds and the input channel stalls. The user must write
// configuration only while no transfer is in flight; the unit does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

`include "fibonacci_sphere_point_gen_unit_defines.svh"

module fibonacci_sphere_point_gen_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_pt_valid,
    output logic             o_pt_stall,
    input  wire logic [11:0] i_point_index,
    output logic             o_coord_valid,
    input  wire logic        i_coord_stall,
    output logic [31:0]      o_coord_x,
    output logic [31:0]      o_coord_y,
    output logic [31:0]      o_coord_z
);
    import fspg_pkg::*;

    function automatic logic [31:0] sat_q(input logic [35:0] mag, input logic neg);
        logic [31:0] res;
        if (!neg) begin
            res = (mag > 36'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        end else begin
            res = (mag > 36'h080000000) ? 32'h80000000 : (~mag[31:0] + 32'd1);
        end
        return res;
    endfunction

    // Configuration registers
    logic [12:0] r_point_count;
    logic [31:0] r_turn_step;
    logic [31:0] r_sphere_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count   <= RST_POINT_COUNT;
            r_turn_step     <= RST_TURN_STEP;
            r_sphere_radius <= RST_SPHERE_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POINT_COUNT:   r_point_count   <= i_cfg_data[12:0];
                CFG_TURN_STEP:     r_turn_step     <= i_cfg_data;
                CFG_SPHERE_RADIUS: r_sphere_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: every stage moves together.
    logic                  adv;
    logic [NUM_STAGES-1:0] r_vld;

    assign adv           = !r_vld[NUM_STAGES-1] || !i_coord_stall;
    assign o_pt_stall    = !adv;
    assign o_coord_valid = r_vld[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_pt_valid};
        end
    end

    // Stage 0: clamp the count, set up the divider, form the phase.
    logic [12:0] n_cnt;
    logic [12:0] n_m13;
    logic [43:0] n_pprod;
    logic [31:0] n_phase;
    logic        n_flip;

    always_comb begin
        n_cnt   = (r_point_count > 13'(MAX_POINTS)) ? 13'(MAX_POINTS) : r_point_count;
        n_m13   = n_cnt - 13'd1;
        n_pprod = 44'(r_turn_step) * 44'(i_point_index);
        n_phase = n_pprod[31:0];
        // Phases in the left half plane are turned by half a turn.
        n_flip  = n_phase[31] ^ n_phase[30];
    end

    logic [11:0]        r_rem  [0:15];
    logic [11:0]        r_m    [0:15];
    logic [15:0]        r_low  [0:15];
    logic [15:0]        r_q    [0:16];
    logic               r_zero [0:16];
    logic               r_one  [0:16];
    logic signed [33:0] r_cx   [0:24];
    logic signed [33:0] r_cy   [0:24];
    logic signed [33:0] r_ang  [0:CORDIC_STEPS-1];
    logic               r_flip [0:24];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0]  <= i_point_index;
            r_m[0]    <= n_m13[11:0];
            r_low[0]  <= 16'(n_m13[11:1]);
            r_q[0]    <= '0;
            r_zero[0] <= (n_cnt <= 13'd1);
            r_one[0]  <= (n_cnt > 13'd1) && ({1'b0, i_point_index} >= n_m13);
            r_cx[0]   <= CORDIC_GAIN;
            r_cy[0]   <= '0;
            r_ang[0]  <= 34'(signed'(n_phase ^ {n_flip, 31'd0}));
            r_flip[0] <= n_flip;
        end
    end

    // Stages 1..16: one quotient bit per stage.
    genvar k;
    generate
        for (k = 0; k < 16; k++) begin : g_div
            logic [12:0] sh;
            logic        qb;
            assign sh = {r_rem[k], r_low[k][15-k]};
            assign qb = (sh >= {1'b0, r_m[k]});
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_q[k+1]    <= {r_q[k][14:0], qb};
                    r_zero[k+1] <= r_zero[k];
                    r_one[k+1]  <= r_one[k];
                end
            end
            if (k < 15) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_rem[k+1] <= qb ? 12'(sh - {1'b0, r_m[k]}) : sh[11:0];
                        r_m[k+1]   <= r_m[k];
                        r_low[k+1] <= r_low[k];
                    end
                end
            end
        end
    endgenerate

    // Stages 1..24: CORDIC rotation, one micro-rotation per stage.
    genvar c;
    generate
        for (c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_flip[c+1] <= r_flip[c];
                    if (!r_ang[c][33]) begin
                        r_cx[c+1] <= r_cx[c] - (r_cy[c] >>> c);
                        r_cy[c+1] <= r_cy[c] + (r_cx[c] >>> c);
                    end else begin
                        r_cx[c+1] <= r_cx[c] + (r_cy[c] >>> c);
                        r_cy[c+1] <= r_cy[c] - (r_cx[c] >>> c);
                    end
                end
            end
            if (c < CORDIC_STEPS - 1) begin : g_ang
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        if (!r_ang[c][33]) begin
                            r_ang[c+1] <= r_ang[c] - {2'b00, ATAN_TURNS[c]};
                        end else begin
                            r_ang[c+1] <= r_ang[c] + {2'b00, ATAN_TURNS[c]};
                        end
                    end
                end
            end
        end
    endgenerate

    // Stages 25..35: hold the rotated vector until the radius is ready.
    logic signed [33:0] r_cxd [25:35];
    logic signed [33:0] r_cyd [25:35];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cxd[25] <= r_flip[24] ? -r_cx[24] : r_cx[24];
            r_cyd[25] <= r_flip[24] ? -r_cy[24] : r_cy[24];
            for (int s = 26; s <= 35; s++) begin
                r_cxd[s] <= r_cxd[s-1];
                r_cyd[s] <= r_cyd[s-1];
            end
        end
    end

    // Stage 17: fraction d, saturated at the poles.
    logic [16:0] r_d17;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_zero[16]) begin
                r_d17 <= '0;
            end else if (r_one[16]) begin
                r_d17 <= ONE_Q16;
            end else begin
                r_d17 <= {1'b0, r_q[16]};
            end
        end
    end

    // Stage 18: z product and d(1-d).
    logic [17:0] n_two_d;
    logic        n_zneg;
    logic [16:0] n_zmag;
    logic [33:0] n_vprod;
    logic [49:0] r_zp18;
    logic        r_zn18;
    logic [30:0] r_sv [18:33];
    logic [31:0] r_sr [18:34];

    always_comb begin
        n_two_d = {r_d17, 1'b0};
        n_zneg  = (n_two_d > 18'(ONE_Q16));
        n_zmag  = n_zneg ? 17'(n_two_d - 18'(ONE_Q16)) : 17'(18'(ONE_Q16) - n_two_d);
        n_vprod = 34'(r_d17) * 34'(ONE_Q16 - r_d17);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_zp18   <= 50'(n_zmag) * 50'(r_sphere_radius) + 50'(1 << (FRAC_BITS - 1));
            r_zn18   <= n_zneg;
            r_sv[18] <= n_vprod[30:0];
            r_sr[18] <= '0;
        end
    end

    // Stages 19..34: integer square root, one result bit per stage.
    genvar j;
    generate
        for (j = 0; j < 16; j++) begin : g_sqrt
            localparam logic [31:0] BIT = 32'(1) << (30 - 2 * j);
            logic [31:0] trial;
            logic        take;
            assign trial = r_sr[18+j] + BIT;
            assign take  = ({1'b0, r_sv[18+j]} >= trial);
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_sr[19+j] <= take ? ((r_sr[18+j] >> 1) + BIT) : (r_sr[18+j] >> 1);
                end
            end
            if (j < 15) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_sv[19+j] <= take ? 31'({1'b0, r_sv[18+j]} - trial) : r_sv[18+j];
                    end
                end
            end
        end
    endgenerate

    // Stages 19..39: z is finished early and rides along.
    logic [31:0] r_z [19:39];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_z[19] <= sat_q(36'(r_zp18[49:16]), r_zn18);
            for (int s = 20; s <= 39; s++) begin
                r_z[s] <= r_z[s-1];
            end
        end
    end

    // Stage 35: horizontal radius product. Stage 36: magnitudes.
    logic [49:0] r_hp35;
    logic [32:0] r_hr36;
    logic [31:0] r_xm36;
    logic [31:0] r_ym36;
    logic        r_xn [36:38];
    logic        r_yn [36:38];
    logic signed [33:0] n_xabs;
    logic signed [33:0] n_yabs;

    assign n_xabs = r_cxd[35][33] ? -r_cxd[35] : r_cxd[35];
    assign n_yabs = r_cyd[35][33] ? -r_cyd[35] : r_cyd[35];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hp35  <= 50'({r_sr[34][15:0], 1'b0}) * 50'(r_sphere_radius)
                     + 50'(1 << (FRAC_BITS - 1));
            r_hr36  <= r_hp35[48:16];
            r_xm36  <= n_xabs[31:0];
            r_ym36  <= n_yabs[31:0];
            r_xn[36] <= r_cxd[35][33];
            r_yn[36] <= r_cyd[35][33];
            r_xn[37] <= r_xn[36];
            r_yn[37] <= r_yn[36];
            r_xn[38] <= r_xn[37];
            r_yn[38] <= r_yn[37];
        end
    end

    // Stage 37: the 32x33 products as two halves. Stage 38: sum and round.
    logic [47:0] r_xlo37;
    logic [48:0] r_xhi37;
    logic [47:0] r_ylo37;
    logic [48:0] r_yhi37;
    logic [65:0] n_xsum;
    logic [65:0] n_ysum;
    logic [35:0] r_xm38;
    logic [35:0] r_ym38;
    logic [31:0] r_x39;
    logic [31:0] r_y39;

    assign n_xsum = (66'(r_xhi37) << 16) + 66'(r_xlo37) + (66'(1) << 29);
    assign n_ysum = (66'(r_yhi37) << 16) + 66'(r_ylo37) + (66'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xlo37 <= 48'(r_xm36) * 48'(r_hr36[15:0]);
            r_xhi37 <= 49'(r_xm36) * 49'(r_hr36[32:16]);
            r_ylo37 <= 48'(r_ym36) * 48'(r_hr36[15:0]);
            r_yhi37 <= 49'(r_ym36) * 49'(r_hr36[32:16]);
            r_xm38  <= n_xsum[65:30];
            r_ym38  <= n_ysum[65:30];
            r_x39   <= sat_q(r_xm38, r_xn[38]);
            r_y39   <= sat_q(r_ym38, r_yn[38]);
        end
    end

    assign o_coord_x = r_x39;
    assign o_coord_y = r_y39;
    assign o_coord_z = r_z[39];

    `FSPG_ASSERT_NXT(a_hold_on_stall, !adv, $stable(r_vld), "pipeline moved while stalled")
    `FSPG_ASSERT_IMP(a_frac_range, r_vld[17], r_d17 <= ONE_Q16, "fraction d above one")
    `FSPG_ASSERT_IMP(a_root_range, r_vld[34], r_sr[34] <= 32'd32768, "square root out of range")

endmodule

`default_nettype wire
